[hw/rtl/pbms_pkg.sv]
// Types and constants shared by the parallel bus master sequencer files.
`default_nettype none
package pbms_pkg;

	localparam int NUM_SLAVES = 4;
	localparam int HOLD_TICKS = 2;
	localparam int HOLD_W     = $clog2(HOLD_TICKS + 1);

	localparam logic [3:0] SEL_NONE  = 4'hF;
	localparam logic [3:0] SEL_ALL   = 4'h0;
	localparam logic [7:0] BUS_IDLE  = 8'hFF;
	localparam logic [1:0] SLAVE_MAX = 2'd3;

	typedef enum logic [2:0] {
		RX_SEL1   = 3'd0,
		RX_WAIT1  = 3'd1,
		RX_CAP1   = 3'd2,
		RX_DESEL1 = 3'd3,
		RX_SEL2   = 3'd4,
		RX_WAIT2  = 3'd5,
		RX_CAP2   = 3'd6,
		RX_DESEL2 = 3'd7
	} rx_phase_t;

	typedef enum logic [2:0] {
		TX_DRIVE1 = 3'd0,
		TX_HOLD1  = 3'd1,
		TX_GAP1   = 3'd2,
		TX_DRIVE2 = 3'd3,
		TX_HOLD2  = 3'd4,
		TX_GAP2   = 3'd5
	} tx_phase_t;

	typedef enum logic {
		REQ_RECEIVE = 1'b0,
		REQ_SEND    = 1'b1
	} req_type_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [7:0] bus_in;
	} cmd_t;

	typedef struct packed {
		logic [3:0] chip_selects_n;
		logic       write_mode;
		logic [7:0] bus_out;
		logic       capture_valid;
		logic [1:0] capture_slave;
		logic       capture_second;
		logic [7:0] capture_byte;
		logic       receive_done;
		logic       send_done;
	} rsp_t;

endpackage
`default_nettype wire

[hw/rtl/pbms_in_if.sv]
// Valid/ready channel that carries one tick item into the sequencer.
`default_nettype none
interface pbms_in_if;
	import pbms_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/pbms_out_if.sv]
// Valid/ready channel that carries one bus result item out of the sequencer.
`default_nettype none
interface pbms_out_if;
	import pbms_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/parallel_bus_master_sequencer.sv]
// Master sequencer for an 8-bit parallel bus with active-low chip selects.
//
// Each item on cmd is one timing tick. A receive tick advances an eight-phase
// poll of the current slave (select, wait, capture, deselect, twice), and a
// send tick advances a two-byte broadcast to all slaves, each byte held with
// the selects low and then with the selects high. Each tick yields exactly
// one item on rsp with the select, read/write and data line levels after the
// tick, any captured byte and the completion pulses.
// An accepted item is registered in the input stage, and its result enters
// the output register once that register is empty or being read by rsp.
// One item is accepted every cycle unless rsp stalls; the throughput is set
// by the single sequencer state update per tick.
// Reset puts both sequencers at their first phase, slave 0, all selects
// high, read mode and 0xFF on the data lines, and empties both stages.
// When the receiver stalls, the output register holds its item, the input
// stage fills, and cmd.ready drops until rsp.ready returns.
`default_nettype none
module parallel_bus_master_sequencer (
	input  wire         clk,
	input  wire         arst_n,
	pbms_in_if.sink     cmd,
	pbms_out_if.source  rsp
);
	import pbms_pkg::*;

	logic              valid_s1;
	cmd_t              item_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_data_q;
	logic              advance;

	rx_phase_t         rx_phase_q, rx_phase_d;
	tx_phase_t         tx_phase_q, tx_phase_d;
	logic [1:0]        slave_q, slave_d;
	logic [HOLD_W-1:0] hold_q, hold_d, hold_dec;
	logic [3:0]        sel_q, sel_d;
	logic              dir_q, dir_d;
	logic [7:0]        data_q, data_d;
	logic [3:0]        slave_mask;
	logic [1:0]        slave_next;
	rsp_t              result;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	assign hold_dec   = (hold_q != '0) ? hold_q - HOLD_W'(1) : hold_q;
	assign slave_mask = (int'(slave_q) < NUM_SLAVES) ? (4'b0001 << slave_q) : 4'b0000;
	assign slave_next = ((int'(slave_q) + 1 >= NUM_SLAVES) || (slave_q == SLAVE_MAX)) ?
			2'd0 : slave_q + 2'd1;

	// Next state of both sequencers.
	always_comb begin
		rx_phase_d = rx_phase_q;
		tx_phase_d = tx_phase_q;
		slave_d    = slave_q;
		hold_d     = hold_q;
		if (item_s1.req_type == REQ_RECEIVE) begin
			case (rx_phase_q)
				RX_DESEL2: begin
					rx_phase_d = RX_SEL1;
					slave_d    = slave_next;
				end
				default: rx_phase_d = rx_phase_t'(rx_phase_q + 3'd1);
			endcase
		end else begin
			hold_d = hold_dec;
			case (tx_phase_q)
				TX_DRIVE1, TX_DRIVE2: begin
					hold_d     = HOLD_W'(HOLD_TICKS);
					tx_phase_d = tx_phase_t'(tx_phase_q + 3'd1);
				end
				TX_HOLD1, TX_HOLD2, TX_GAP1: begin
					if (hold_dec == '0) begin
						hold_d     = HOLD_W'(HOLD_TICKS);
						tx_phase_d = tx_phase_t'(tx_phase_q + 3'd1);
					end
				end
				TX_GAP2: begin
					if (hold_dec == '0) begin
						hold_d     = HOLD_W'(HOLD_TICKS);
						tx_phase_d = TX_DRIVE1;
						rx_phase_d = RX_SEL1;
						slave_d    = 2'd0;
					end
				end
				default: tx_phase_d = TX_DRIVE1;
			endcase
		end
	end

	// Bus line levels and the result item.
	always_comb begin
		sel_d  = sel_q;
		dir_d  = dir_q;
		data_d = data_q;
		result = '0;
		if (item_s1.req_type == REQ_RECEIVE) begin
			case (rx_phase_q)
				RX_SEL1: begin
					sel_d = SEL_NONE & ~slave_mask;
					dir_d = 1'b0;
				end
				RX_SEL2: begin
					sel_d = sel_q & ~slave_mask;
					dir_d = 1'b0;
				end
				RX_CAP1, RX_CAP2: begin
					result.capture_valid  = 1'b1;
					result.capture_slave  = slave_q;
					result.capture_second = (rx_phase_q == RX_CAP2);
					result.capture_byte   = item_s1.bus_in;
				end
				RX_DESEL1: sel_d = SEL_NONE;
				RX_DESEL2: begin
					sel_d               = SEL_NONE;
					result.receive_done = 1'b1;
				end
				default: ;
			endcase
		end else begin
			case (tx_phase_q)
				TX_DRIVE1, TX_DRIVE2: begin
					sel_d  = SEL_ALL;
					dir_d  = 1'b1;
					data_d = (tx_phase_q == TX_DRIVE1) ? item_s1.first_byte :
							item_s1.second_byte;
				end
				TX_GAP1: sel_d = SEL_NONE;
				TX_GAP2: begin
					sel_d = SEL_NONE;
					if (hold_dec == '0) begin
						data_d           = BUS_IDLE;
						result.send_done = 1'b1;
					end
				end
				default: ;
			endcase
		end
		result.chip_selects_n = sel_d;
		result.write_mode     = dir_d;
		result.bus_out        = data_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			rx_phase_q  <= RX_SEL1;
			tx_phase_q  <= TX_DRIVE1;
			slave_q     <= 2'd0;
			hold_q      <= '0;
			sel_q       <= SEL_NONE;
			dir_q       <= 1'b0;
			data_q      <= BUS_IDLE;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
				rx_phase_q  <= rx_phase_d;
				tx_phase_q  <= tx_phase_d;
				slave_q     <= slave_d;
				hold_q      <= hold_d;
				sel_q       <= sel_d;
				dir_q       <= dir_d;
				data_q      <= data_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
		if (advance) begin
			rsp_data_q <= result;
		end
	end

	a_done_deselects: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_data_q.receive_done || rsp_data_q.send_done)
		|-> rsp_data_q.chip_selects_n == SEL_NONE)
		else $error("completion item with a chip select still low");

	a_send_done_idle_bus: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) && rsp_data_q.send_done
		|-> rsp_data_q.bus_out == BUS_IDLE && rx_phase_q == RX_SEL1 && slave_q == 2'd0)
		else $error("broadcast end did not release the bus or restart polling");

	a_tx_phase_reachable: assert property (@(posedge clk) disable iff (!arst_n)
		tx_phase_q != 3'd6 && tx_phase_q != 3'd7)
		else $error("send sequencer in an unreachable phase");

	a_hold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(hold_q) <= HOLD_TICKS)
		else $error("hold counter above its load value");

	a_capture_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_data_q.capture_valid
		|-> !rsp_data_q.send_done && !rsp_data_q.receive_done && !rsp_data_q.write_mode
		|| rsp_data_q.capture_valid && !rsp_data_q.send_done && !rsp_data_q.receive_done)
		else $error("capture item also reports a completion");

endmodule
`default_nettype wire
